FILE: hw/rtl/jacobi_laplace_stencil_sweep_assert.svh
// ----------------------------------------------------------------------------
// Jacobi stencil sweep assertion macros
// Shared concurrent assertion forms, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef JACOBI_LAPLACE_STENCIL_SWEEP_ASSERT_SVH
`define JACOBI_LAPLACE_STENCIL_SWEEP_ASSERT_SVH

// same-cycle implication
`define JLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jls: same-cycle check failed");

// next-cycle implication
`define JLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jls: next-cycle check failed");

`endif

FILE: hw/rtl/jls_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi stencil sweep package
// Sizes, widths and register map of the 5-point stencil sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jls_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int LINE_DEPTH = MAX_COLS + 2;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int COL_W      = 11;
  localparam int ROW_W      = 16;
  localparam int ROWCNT_W   = ROW_W + 1;
  localparam int VAL_W      = 16;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [0:0] {
    REG_INTERIOR_COLS = 1'b0,
    REG_INTERIOR_ROWS = 1'b1
  } reg_idx_e;

endpackage

FILE: hw/rtl/jacobi_laplace_stencil_sweep.sv
// Output: the result of an accepted word is registered.
// Throughput: one word per cycle unless res_stall_i holds a valid result;
// the line stores take one read and one write each per cycle, reading one word ahead.
// Reset: interior_cols and interior_rows go to 1024, position counters,
// window and running maximum to zero; the line stores are not cleared.
// ----------------------------------------------------------------------------
// Jacobi stencil sweep
// Streams the old grid in raster order and emits the 4-neighbour average
// of each interior cell plus the frame's largest absolute change.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "jacobi_laplace_stencil_sweep_assert.svh"

module jacobi_laplace_stencil_sweep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jls_pkg::PADDR_W-1:0]   paddr,
  input  logic [jls_pkg::PDATA_W-1:0]   pwdata,
  output logic [jls_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [jls_pkg::VAL_W-1:0]     cell_value_i,
  // result channel
  output logic                          res_valid_o,
  input  logic                          res_stall_i,
  output logic                          out_valid_o,
  output logic [jls_pkg::VAL_W-1:0]     new_value_o,
  output logic                          frame_done_o,
  output logic [jls_pkg::VAL_W-1:0]     max_change_o
);
  import jls_pkg::*;

  // configuration
  logic [COL_W-1:0]    cols_q;
  logic [ROW_W-1:0]    rows_q;
  logic [COL_W-1:0]    cols_eff;
  logic [ROW_W-1:0]    rows_eff;
  logic                cfg_we;

  // position and window
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROWCNT_W-1:0] row_q, row_d;
  val_t                win1_q, win2_q;
  val_t                x_prev_q;
  val_t                run_q, run_d;

  // line stores
  val_t                l1_mem [LINE_DEPTH];
  val_t                l2_mem [LINE_DEPTH];
  val_t                l1_rd_q;
  val_t                l2_rd_q;
  logic [ADDR_W-1:0]   l2_rd_addr;
  logic                l2_we;
  logic [ADDR_W-1:0]   l2_wr_addr;
  val_t                l2_wr_data;
  logic                l2_pend_q;
  logic [ADDR_W-1:0]   l2_pend_addr_q;
  val_t                l2_pend_data_q;

  // datapath
  logic                acc;
  logic                row_end;
  logic                frame_end;
  logic                interior;
  logic [VAL_W+1:0]    sum;
  val_t                new_val;
  val_t                diff;
  val_t                max_upd;

  // result register
  logic                res_valid_q;
  logic                out_valid_q;
  val_t                new_value_q;
  logic                frame_done_q;
  val_t                max_change_q;

  assign acc        = in_valid_i && !in_stall_o;
  assign in_stall_o = res_valid_q && res_stall_i;
  assign cfg_we     = psel && penable && pwrite;
  assign pready     = 1'b1;

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_INTERIOR_COLS: prdata = {{(PDATA_W-COL_W){1'b0}}, cols_q};
      REG_INTERIOR_ROWS: prdata = {{(PDATA_W-ROW_W){1'b0}}, rows_q};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COL_W'(MAX_COLS);
      rows_q <= ROW_W'(1024);
    end else if (cfg_we) begin
      case (reg_idx_e'(paddr[2]))
        REG_INTERIOR_COLS: cols_q <= pwdata[COL_W-1:0];
        REG_INTERIOR_ROWS: rows_q <= pwdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize columns clamp to MAX_COLS
  always_comb begin
    if (cols_q == '0) begin
      cols_eff = COL_W'(1);
    end else if (cols_q > COL_W'(MAX_COLS)) begin
      cols_eff = COL_W'(MAX_COLS);
    end else begin
      cols_eff = cols_q;
    end
    rows_eff = (rows_q == '0) ? ROW_W'(1) : rows_q;
  end

  always_comb begin
    row_end   = col_q >= (cols_eff + COL_W'(1));
    frame_end = row_q >= ({1'b0, rows_eff} + ROWCNT_W'(1));
    interior  = (row_q >= ROWCNT_W'(2)) && (row_q <= ({1'b0, rows_eff} + ROWCNT_W'(1)))
             && (col_q >= COL_W'(2)) && (col_q <= (cols_eff + COL_W'(1)));

    if (row_end) begin
      col_d = '0;
      row_d = frame_end ? '0 : row_q + ROWCNT_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
      row_d = row_q;
    end

    // left, right, up, down; center is the word leaving the window middle
    sum = {2'b00, win1_q} + {2'b00, l1_rd_q} + {2'b00, l2_rd_q} + {2'b00, x_prev_q};
    new_val = sum[VAL_W+1:2];
    diff    = (new_val >= win2_q) ? new_val - win2_q : win2_q - new_val;
    max_upd = (interior && (diff > run_q)) ? diff : run_q;
    run_d   = (row_end && frame_end) ? '0 : max_upd;

    l2_rd_addr = (col_d == '0) ? '0 : ADDR_W'(col_d - COL_W'(1));

    // a step past column zero owns the port; else drain the row-end write
    if (acc && (col_q != '0)) begin
      l2_we      = 1'b1;
      l2_wr_addr = ADDR_W'(col_q - COL_W'(1));
      l2_wr_data = win2_q;
    end else begin
      l2_we      = l2_pend_q;
      l2_wr_addr = l2_pend_addr_q;
      l2_wr_data = l2_pend_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      win1_q      <= '0;
      win2_q      <= '0;
      run_q       <= '0;
      l2_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      l2_pend_q <= acc && row_end;
      if (acc) begin
        col_q       <= col_d;
        row_q       <= row_d;
        win1_q      <= win2_q;
        win2_q      <= l1_rd_q;
        run_q       <= run_d;
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      x_prev_q       <= cell_value_i;
      l2_pend_addr_q <= ADDR_W'(col_q);
      l2_pend_data_q <= l1_rd_q;
      out_valid_q    <= interior;
      new_value_q    <= interior ? new_val : '0;
      frame_done_q   <= row_end && frame_end;
      max_change_q   <= (row_end && frame_end) ? max_upd : '0;
    end
  end

  // row above: read one word ahead, replace the current column
  always_ff @(posedge clk_i) begin
    if (acc) begin
      l1_mem[ADDR_W'(col_q)] <= cell_value_i;
      l1_rd_q                <= l1_mem[ADDR_W'(col_d)];
    end
  end

  // row two above
  always_ff @(posedge clk_i) begin
    if (l2_we) begin
      l2_mem[l2_wr_addr] <= l2_wr_data;
    end
    if (acc) begin
      l2_rd_q <= l2_mem[l2_rd_addr];
    end
  end

  assign res_valid_o  = res_valid_q;
  assign out_valid_o  = out_valid_q;
  assign new_value_o  = new_value_q;
  assign frame_done_o = frame_done_q;
  assign max_change_o = max_change_q;

  `JLS_ASSERT_NXT(a_row_end_wraps, clk_i, rst_ni, acc && row_end, col_q == '0)
  `JLS_ASSERT_IMP(a_pend_no_clash, clk_i, rst_ni, l2_pend_q && acc, col_q == '0)
  `JLS_ASSERT_IMP(a_max_only_done, clk_i, rst_ni, res_valid_o && !frame_done_o, max_change_o == '0)
  `JLS_ASSERT_IMP(a_empty_no_stall, clk_i, rst_ni, !res_valid_o, !in_stall_o)

endmodule
